// ===== design/ssort_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssort_pkg: shared types and constants of the signed array sorter
// Holds the set size, data and count widths, the cell link and command
// structs, and the controller state type.
// ----------------------------------------------------------------------------
package ssort_pkg;

  localparam int SIZE   = 16;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(SIZE + 1);

  // What one cell shows its neighbors
  typedef struct packed {
    logic signed [DATA_W-1:0] held;  // stored element
    logic                     occ;   // cell holds an element
    logic                     gt;    // new element belongs at or before this cell
  } ssort_link_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;        // insert the broadcast element
    logic shift_out;  // move every element one cell toward the head
  } ssort_cmd_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } ssort_state_t;

endpackage

// ===== design/ssort_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssort_cell: one insertion cell of the sorting chain
// Keeps one element; on insert it keeps, takes its left neighbor's element
// or the new element; on drain it takes its right neighbor's element.
// ----------------------------------------------------------------------------
module ssort_cell (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  ssort_pkg::ssort_cmd_t                 cmd,
  input  logic signed [ssort_pkg::DATA_W-1:0]   din,
  input  ssort_pkg::ssort_link_t                left,
  input  ssort_pkg::ssort_link_t                right,
  output ssort_pkg::ssort_link_t                link
);
  import ssort_pkg::*;

  logic signed [DATA_W-1:0] held_r, held_nxt;
  logic                     occ_r, occ_nxt;
  logic                     gt;

  // Flag cells whose element is larger than the new one, or that are empty
  assign gt = !occ_r || (din < held_r);

  // Pick the next element: drain shifts left, insert shifts right
  always_comb begin
    held_nxt = held_r;
    occ_nxt  = occ_r;
    if (cmd.shift_out) begin
      held_nxt = right.held;
      occ_nxt  = right.occ;
    end else if (cmd.ins && gt) begin
      held_nxt = left.gt ? left.held : din;
      occ_nxt  = left.occ;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

  assign link.held = held_r;
  assign link.occ  = occ_r;
  assign link.gt   = gt;

endmodule

// ===== design/ssort_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssort_chain: row of insertion cells kept in ascending order
// Cell 0 holds the smallest element and feeds the output on drain.
// ----------------------------------------------------------------------------
module ssort_chain (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  ssort_pkg::ssort_cmd_t                 cmd,
  input  logic signed [ssort_pkg::DATA_W-1:0]   din,
  output ssort_pkg::ssort_link_t                head
);
  import ssort_pkg::*;

  ssort_link_t links [SIZE];
  ssort_link_t left_edge, right_edge;

  // Left edge counts as occupied and smaller; right edge as empty
  assign left_edge  = '{held: '0, occ: 1'b1, gt: 1'b0};
  assign right_edge = '{held: '0, occ: 1'b0, gt: 1'b0};

  for (genvar i = 0; i < SIZE; i++) begin : g_cell
    ssort_link_t lft, rgt;

    if (i == 0) begin : g_first
      assign lft = left_edge;
    end else begin : g_mid_l
      assign lft = links[i-1];
    end

    if (i == SIZE - 1) begin : g_last
      assign rgt = right_edge;
    end else begin : g_mid_r
      assign rgt = links[i+1];
    end

    ssort_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (cmd),
      .din   (din),
      .left  (lft),
      .right (rgt),
      .link  (links[i])
    );
  end

  assign head = links[0];

endmodule

// ===== design/signed_array_sorter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_array_sorter_core: sorts a set of signed 32-bit elements
// Collects a set into a chain of insertion cells, then streams it out in
// ascending order with last and overflow flags.
//
//   channel | ports                                        | direction
//   in      | in_valid, in_ready, in_value, in_last        | request in
//   out     | out_valid, out_ready, out_sorted_value,      | request out
//           | out_last_out, out_overflow                   |
//
// Each element is inserted into the cell chain in place as it is accepted,
// and each result leaves from the chain head into the output register while
// that register is empty or its result is being taken.
// The input is held off while a set drains; the next set is taken once the
// final result sits in the output register.
// Reset (rst_n low, synchronous) empties the chain and clears count, overflow and out_valid.
// ----------------------------------------------------------------------------
module signed_array_sorter_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [ssort_pkg::DATA_W-1:0]   in_value,
  input  logic                                  in_last,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [ssort_pkg::DATA_W-1:0]   out_sorted_value,
  output logic                                  out_last_out,
  output logic                                  out_overflow
);
  import ssort_pkg::*;

  ssort_state_t             state_r, state_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     ovf_r, ovf_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_value_r;
  logic                     out_last_r, out_ovf_r;

  logic                     in_acc;
  logic                     full;
  logic                     out_load;
  logic                     final_one;
  ssort_cmd_t               cmd;
  ssort_link_t              head;

  assign full      = (count_r == CNT_W'(SIZE));
  assign final_one = (count_r == CNT_W'(1));
  assign in_acc    = in_valid && in_ready;

  // Drive handshake and chain commands from the state
  always_comb begin
    in_ready      = 1'b0;
    out_load      = 1'b0;
    unique case (state_r)
      ST_LOAD:  in_ready = 1'b1;
      ST_DRAIN: out_load = !out_valid_r || out_ready;
      default: ;
    endcase
    cmd.ins       = in_acc && !full;
    cmd.shift_out = out_load;
  end

  // Advance between collecting and draining
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD:  if (in_acc && in_last) state_nxt = ST_DRAIN;
      ST_DRAIN: if (out_load && final_one) state_nxt = ST_LOAD;
      default:  state_nxt = ST_LOAD;
    endcase
  end

  // Track held elements and dropped ones
  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (out_load) begin
      count_nxt = count_r - CNT_W'(1);
    end
    ovf_nxt = ovf_r;
    if (in_acc && full) begin
      ovf_nxt = 1'b1;
    end else if (out_load && final_one) begin
      ovf_nxt = 1'b0;
    end
    out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the result from the chain head until taken
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r <= head.held;
      out_last_r  <= final_one;
      out_ovf_r   <= ovf_r;
    end
  end

  ssort_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .din   (in_value),
    .head  (head)
  );

  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_value_r;
  assign out_last_out     = out_last_r;
  assign out_overflow     = out_ovf_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(SIZE))
    else $error("element count above set size");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DRAIN |-> count_r != '0)
    else $error("draining with no held element");

  a_head_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    head.occ == (count_r != '0))
    else $error("chain head occupancy disagrees with count");

  a_drain_ends_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DRAIN && out_load && final_one
      |=> state_r == ST_LOAD && count_r == '0 && !ovf_r && out_last_out)
    else $error("set did not close cleanly");
`endif

endmodule
